// File: rtl/core/hwt_pkg.sv
// Package with the shared constants, codes, types and helper functions of the timer wheel.
package hwt_pkg;

    // Entry pointers are seven bits wide, with one code meaning "no entry".
    localparam int ENTRY_W = 7;
    localparam logic [ENTRY_W-1:0] NIL_ENTRY = 7'd127;
    localparam int DEF_MAX_TIMERS = 64;

    // Slot store layout: seconds, minutes, hours, days.
    localparam int NUM_SLOTS = 174;
    localparam int SLOT_W = 8;
    localparam logic [SLOT_W-1:0] SEC_OFF = 8'd0;
    localparam logic [SLOT_W-1:0] MIN_OFF = 8'd60;
    localparam logic [SLOT_W-1:0] HOUR_OFF = 8'd120;
    localparam logic [SLOT_W-1:0] DAY_OFF = 8'd144;

    // Field widths.
    localparam int ID_W = 16;
    localparam int DELAY_W = 22;
    localparam int TIME_W = 63;
    localparam int INFO_W = 39;

    // Delays of 31 days and more are refused.
    localparam logic [DELAY_W-1:0] DELAY_LIMIT = 22'd2678400;
    localparam logic [DELAY_W-1:0] MIN_SECS = 22'd60;
    localparam logic [DELAY_W-1:0] HOUR_SECS = 22'd3600;
    localparam logic [DELAY_W-1:0] DAY_SECS = 22'd86400;

    // Reciprocals scaled by 2^32, rounded down.
    localparam logic [26:0] RECIP_MIN = 27'd71582788;
    localparam logic [26:0] RECIP_HOUR = 27'd1193046;
    localparam logic [26:0] RECIP_DAY = 27'd49710;

    // At most this many firings are reported per item.
    localparam logic [6:0] MAX_RESULTS = 7'd64;

    // Input opcodes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Result kinds and status codes.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRED = 1'b1;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Command codes passed from the front to the back.
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REJECT = 2'd2;
    localparam logic [1:0] CMD_ZERO = 2'd3;

    // Wheel level codes.
    localparam logic [1:0] LVL_SEC = 2'd0;
    localparam logic [1:0] LVL_MIN = 2'd1;
    localparam logic [1:0] LVL_HOUR = 2'd2;
    localparam logic [1:0] LVL_DAY = 2'd3;

    // One classified command in the queue.
    typedef struct packed {
        logic [1:0]         op;
        logic [ID_W-1:0]    id;
        logic [DELAY_W-1:0] dly;
        logic               per;
        logic [3:0]         adv;
    } cmd_t;

    // Handshake group between the front and the queue.
    typedef struct packed {
        logic push;
        cmd_t cmd;
    } push_t;

    // Handshake group between the queue and the back.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

    // First slot of a level.
    function automatic logic [SLOT_W-1:0] lvl_off(input logic [1:0] lvl);
        logic [SLOT_W-1:0] r;
        case (lvl)
            LVL_SEC:  r = SEC_OFF;
            LVL_MIN:  r = MIN_OFF;
            LVL_HOUR: r = HOUR_OFF;
            default:  r = DAY_OFF;
        endcase
        return r;
    endfunction

    // Number of slots of a level.
    function automatic logic [6:0] lvl_size(input logic [1:0] lvl);
        logic [6:0] r;
        case (lvl)
            LVL_SEC:  r = 7'd60;
            LVL_MIN:  r = 7'd60;
            LVL_HOUR: r = 7'd24;
            default:  r = 7'd30;
        endcase
        return r;
    endfunction

    // Seconds per slot of a level.
    function automatic logic [DELAY_W-1:0] lvl_unit(input logic [1:0] lvl);
        logic [DELAY_W-1:0] r;
        case (lvl)
            LVL_SEC:  r = 22'd1;
            LVL_MIN:  r = MIN_SECS;
            LVL_HOUR: r = HOUR_SECS;
            default:  r = DAY_SECS;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/hierarchical_timer_wheel_unit.sv
// Top level of the four-level timer wheel: front end, command queue and back end.
// A tick item advances the second wheel, and the minute, hour and day wheels on their
// boundaries; due timers come out one result item each, in the order they reached their slot,
// with periodic timers re-armed. An insert item gives one status result (two for a zero delay).
// The front end takes a new item whenever its two-entry command queue has room, so items keep
// flowing while the back end works and while a result waits in the output register. The back
// end handles one command at a time and releases it from the queue in S_FIN. An insert
// that files a timer passes S_INS, S_INS2, the filing steps S_PDIV, S_PFIX, S_PRD and
// S_PAPP, then S_INS3 and S_EMIT; a refused, rejected or zero-delay insert only emits its
// results. A tick visits S_ADV per level; a level that advances passes S_ADV2, and each entry
// of its detached slot passes S_WCHK, S_WDATA, S_EMIT and S_FPOST if it fires, the filing
// steps if filed again, and S_WNEXT; filing follows registered slot and entry reads. Result
// delivery stalls the sequencer only when the output register is still full. No clearing pass
// is needed after reset: valid bits stand in for the empty slot and free chain contents.
module hierarchical_timer_wheel_unit
    import hwt_pkg::*;
#(
    parameter int MAX_TIMERS = DEF_MAX_TIMERS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [TIME_W-1:0]  now,
    input  logic [ID_W-1:0]    timer_id,
    input  logic [DELAY_W-1:0] delay,
    input  logic               periodic,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [ID_W-1:0]    fired_id,
    output logic [1:0]         status,
    output logic               last
);

    push_t q_push;
    head_t q_head;
    logic  q_full;
    logic  q_pop;

    // Item intake and classification.
    hwt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .now      (now),
        .timer_id (timer_id),
        .delay    (delay),
        .periodic (periodic),
        .q_full   (q_full),
        .q_push   (q_push)
    );

    // Command queue.
    hwt_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_full (q_full),
        .q_head (q_head),
        .q_pop  (q_pop)
    );

    // Wheel sequencer and stores.
    hwt_back #(
        .MAX_TIMERS (MAX_TIMERS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .fired_id  (fired_id),
        .status    (status),
        .last      (last)
    );

endmodule

// File: rtl/core/hwt_front.sv
// Front end: accepts input items, keeps the tick clock and classifies each item into a command.
module hwt_front
    import hwt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [TIME_W-1:0]  now,
    input  logic [ID_W-1:0]    timer_id,
    input  logic [DELAY_W-1:0] delay,
    input  logic               periodic,
    input  logic               q_full,
    output push_t              q_push
);

    logic              started_reg;
    logic [TIME_W-1:0] last_time_reg;
    logic [5:0]        sec_cnt_reg;
    logic [5:0]        min_cnt_reg;
    logic [4:0]        hour_cnt_reg;
    logic              accept;
    logic              min_wrap;
    logic              hour_wrap;
    logic              day_wrap;
    logic              tick_ok;

    assign in_ready = !q_full;
    assign accept = in_valid && !q_full;

    // Wrap flags of the second, minute and hour counters for the coming tick.
    assign min_wrap = (sec_cnt_reg == 6'd59);
    assign hour_wrap = min_wrap && (min_cnt_reg == 6'd59);
    assign day_wrap = hour_wrap && (hour_cnt_reg == 5'd23);
    assign tick_ok = started_reg && (now >= last_time_reg);

    // Classification of the accepted item.
    always_comb
    begin
        q_push.push = 1'b0;
        q_push.cmd.op = CMD_TICK;
        q_push.cmd.id = timer_id;
        q_push.cmd.dly = delay;
        q_push.cmd.per = periodic;
        q_push.cmd.adv = {day_wrap, hour_wrap, min_wrap, 1'b1};
        if (accept)
        begin
            if (opcode == OP_INSERT)
            begin
                q_push.push = 1'b1;
                if (delay >= DELAY_LIMIT)
                begin
                    q_push.cmd.op = CMD_REJECT;
                end
                else if (delay == '0)
                begin
                    q_push.cmd.op = CMD_ZERO;
                end
                else
                begin
                    q_push.cmd.op = CMD_INSERT;
                end
            end
            else
            begin
                q_push.push = tick_ok;
            end
        end
    end

    // Tick clock state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            last_time_reg <= '0;
            sec_cnt_reg <= '0;
            min_cnt_reg <= '0;
            hour_cnt_reg <= '0;
        end
        else if (accept && opcode == OP_TICK)
        begin
            if (!started_reg)
            begin
                started_reg <= 1'b1;
                last_time_reg <= now;
            end
            else if (tick_ok)
            begin
                last_time_reg <= now;
                sec_cnt_reg <= min_wrap ? 6'd0 : sec_cnt_reg + 6'd1;
                if (min_wrap)
                begin
                    min_cnt_reg <= hour_wrap ? 6'd0 : min_cnt_reg + 6'd1;
                end
                if (hour_wrap)
                begin
                    hour_cnt_reg <= day_wrap ? 5'd0 : hour_cnt_reg + 5'd1;
                end
            end
        end
    end

endmodule

// File: rtl/core/hwt_queue.sv
// Two-entry command queue between the front end and the back end.
module hwt_queue
    import hwt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t q_push,
    output logic  q_full,
    output head_t q_head,
    input  logic  q_pop
);

    cmd_t       slots_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign q_full = (count_reg == 2'd2);
    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.cmd = slots_reg[rd_ptr_reg];
    assign do_push = q_push.push && !q_full;
    assign do_pop = q_pop && q_head.valid;

    // Payload storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= q_push.cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// File: rtl/core/hwt_back.sv
// Back end: slot and entry stores, the sequencer that files and walks timers, and the result register.
module hwt_back
    import hwt_pkg::*;
#(
    parameter int MAX_TIMERS = DEF_MAX_TIMERS
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  head_t           q_head,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            kind,
    output logic [ID_W-1:0] fired_id,
    output logic [1:0]      status,
    output logic            last
);

    localparam int EW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_ZERO2 = 5'd1;
    localparam logic [4:0] S_INS   = 5'd2;
    localparam logic [4:0] S_INS2  = 5'd3;
    localparam logic [4:0] S_INS3  = 5'd4;
    localparam logic [4:0] S_ADV   = 5'd5;
    localparam logic [4:0] S_ADV2  = 5'd6;
    localparam logic [4:0] S_WCHK  = 5'd7;
    localparam logic [4:0] S_WDATA = 5'd8;
    localparam logic [4:0] S_FPOST = 5'd9;
    localparam logic [4:0] S_WNEXT = 5'd10;
    localparam logic [4:0] S_EMIT  = 5'd11;
    localparam logic [4:0] S_FIN   = 5'd12;
    localparam logic [4:0] S_PDIV  = 5'd13;
    localparam logic [4:0] S_PFIX  = 5'd14;
    localparam logic [4:0] S_PRD   = 5'd15;
    localparam logic [4:0] S_PAPP  = 5'd16;

    // Stores.
    logic [ENTRY_W-1:0] head_mem [NUM_SLOTS];
    logic               head_vld_reg [NUM_SLOTS];
    logic [ENTRY_W-1:0] tail_mem [NUM_SLOTS];
    logic [ENTRY_W-1:0] next_mem [MAX_TIMERS];
    logic               next_vld_reg [MAX_TIMERS];
    logic [DELAY_W-1:0] rem_mem [MAX_TIMERS];
    logic [INFO_W-1:0]  info_mem [MAX_TIMERS];

    // Registered read data.
    logic [ENTRY_W-1:0] head_raw_reg;
    logic               head_rv_reg;
    logic [ENTRY_W-1:0] tail_rd_reg;
    logic [ENTRY_W-1:0] next_raw_reg;
    logic               next_rv_reg;
    logic [ENTRY_W-1:0] next_rst_reg;
    logic [DELAY_W-1:0] rem_rd_reg;
    logic [INFO_W-1:0]  info_rd_reg;
    logic [ENTRY_W-1:0] head_rd;
    logic [ENTRY_W-1:0] next_rd;

    // Sequencer state.
    logic [4:0]         state_reg;
    logic [4:0]         ret_e_reg;
    logic [4:0]         ret_p_reg;
    logic [1:0]         lvl_reg;
    logic [5:0]         base_reg [4];
    logic [ENTRY_W-1:0] free_head_reg;
    logic [ENTRY_W-1:0] e_reg;
    logic [ENTRY_W-1:0] nx_reg;
    logic               f_per_reg;
    logic [DELAY_W-1:0] f_dly_reg;
    logic [6:0]         n_reg;

    // Pending result.
    logic               pend_v_reg;
    logic               pend_kind_reg;
    logic [ID_W-1:0]    pend_id_reg;
    logic [1:0]         pend_st_reg;
    logic               em_kind_reg;
    logic [ID_W-1:0]    em_id_reg;
    logic [1:0]         em_st_reg;

    // Filing registers.
    logic [ENTRY_W-1:0] pl_e_reg;
    logic [DELAY_W-1:0] pl_d_reg;
    logic [1:0]         plv_reg;
    logic [16:0]        q0_reg;
    logic [SLOT_W-1:0]  p_slot_reg;
    logic [DELAY_W-1:0] p_rem_reg;

    // Memory port signals.
    logic [SLOT_W-1:0]  head_ra;
    logic               head_we;
    logic [SLOT_W-1:0]  head_wa;
    logic [ENTRY_W-1:0] head_wd;
    logic               tail_we;
    logic [ENTRY_W-1:0] tail_wd;
    logic [ENTRY_W-1:0] next_ra;
    logic               next_we;
    logic [ENTRY_W-1:0] next_wa;
    logic [ENTRY_W-1:0] next_wd;
    logic               rem_we;
    logic               info_we;
    logic [SLOT_W-1:0]  adv_slot;
    logic               adv_on;
    logic               can_push;
    logic               push_pend;
    logic               push_last;

    // Filing arithmetic.
    logic [1:0]         d_lvl;
    logic [26:0]        d_recip;
    logic [48:0]        d_prod;
    logic [DELAY_W-1:0] f_unit;
    logic [33:0]        f_qc;
    logic [DELAY_W:0]   f_r0;
    logic [16:0]        f_q;
    logic [DELAY_W-1:0] f_r;
    logic [5:0]         f_units;
    logic [6:0]         f_sum;
    logic [6:0]         f_size;
    logic [6:0]         f_slot_in;

    assign head_rd = head_rv_reg ? head_raw_reg : NIL_ENTRY;
    assign next_rd = next_rv_reg ? next_raw_reg : next_rst_reg;
    assign adv_slot = lvl_off(lvl_reg) + SLOT_W'(base_reg[lvl_reg]);
    assign adv_on = q_head.cmd.adv[lvl_reg];
    assign can_push = !out_valid || out_ready;

    // Level choice and reciprocal product for the quotient estimate.
    always_comb
    begin
        if (pl_d_reg < MIN_SECS)
        begin
            d_lvl = LVL_SEC;
            d_recip = '0;
        end
        else if (pl_d_reg < HOUR_SECS)
        begin
            d_lvl = LVL_MIN;
            d_recip = RECIP_MIN;
        end
        else if (pl_d_reg < DAY_SECS)
        begin
            d_lvl = LVL_HOUR;
            d_recip = RECIP_HOUR;
        end
        else
        begin
            d_lvl = LVL_DAY;
            d_recip = RECIP_DAY;
        end
        d_prod = 49'(pl_d_reg) * 49'(d_recip);
    end

    // Quotient correction, remainder and target slot.
    always_comb
    begin
        f_unit = lvl_unit(plv_reg);
        f_qc = 34'(q0_reg) * 34'(f_unit);
        f_r0 = (DELAY_W+1)'(34'(pl_d_reg) - f_qc);
        if (f_r0 >= (DELAY_W+1)'(f_unit))
        begin
            f_q = q0_reg + 17'd1;
            f_r = DELAY_W'(f_r0 - (DELAY_W+1)'(f_unit));
        end
        else
        begin
            f_q = q0_reg;
            f_r = DELAY_W'(f_r0);
        end
        if (plv_reg == LVL_SEC)
        begin
            f_units = pl_d_reg[5:0];
            f_r = '0;
        end
        else
        begin
            f_units = f_q[5:0];
        end
        f_size = lvl_size(plv_reg);
        f_sum = 7'(base_reg[plv_reg]) + 7'(f_units) - 7'd1;
        f_slot_in = (f_sum >= f_size) ? f_sum - f_size : f_sum;
    end

    // Memory address and write selection.
    always_comb
    begin
        head_ra = p_slot_reg;
        head_we = 1'b0;
        head_wa = p_slot_reg;
        head_wd = pl_e_reg;
        tail_we = 1'b0;
        tail_wd = pl_e_reg;
        next_ra = e_reg;
        next_we = 1'b0;
        next_wa = pl_e_reg;
        next_wd = NIL_ENTRY;
        rem_we = 1'b0;
        info_we = 1'b0;
        case (state_reg)
            S_INS:
            begin
                next_ra = free_head_reg;
            end
            S_INS2:
            begin
                info_we = 1'b1;
            end
            S_ADV:
            begin
                head_ra = adv_slot;
                head_wa = adv_slot;
                head_wd = NIL_ENTRY;
                tail_wd = NIL_ENTRY;
                head_we = adv_on;
                tail_we = adv_on;
            end
            S_FPOST:
            begin
                if (!(f_per_reg && f_dly_reg != '0))
                begin
                    next_we = 1'b1;
                    next_wa = e_reg;
                    next_wd = free_head_reg;
                end
            end
            S_PRD:
            begin
                next_we = 1'b1;
                rem_we = 1'b1;
            end
            S_PAPP:
            begin
                tail_we = 1'b1;
                if (head_rd == NIL_ENTRY)
                begin
                    head_we = 1'b1;
                end
                else
                begin
                    next_we = 1'b1;
                    next_wa = tail_rd_reg;
                    next_wd = pl_e_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Slot stores, read first.
    always_ff @(posedge clk)
    begin
        head_raw_reg <= head_mem[head_ra];
        tail_rd_reg <= tail_mem[head_ra];
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        if (tail_we)
        begin
            tail_mem[head_wa] <= tail_wd;
        end
    end

    // Valid bits of the slot heads; a slot never written reads as empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                head_vld_reg[i] <= 1'b0;
            end
            head_rv_reg <= 1'b0;
        end
        else
        begin
            head_rv_reg <= head_vld_reg[head_ra];
            if (head_we)
            begin
                head_vld_reg[head_wa] <= 1'b1;
            end
        end
    end

    // Entry stores.
    always_ff @(posedge clk)
    begin
        next_raw_reg <= next_mem[next_ra[EW-1:0]];
        next_rst_reg <= (int'(next_ra[EW-1:0]) + 1 < MAX_TIMERS) ?
                        ENTRY_W'(int'(next_ra[EW-1:0]) + 1) : NIL_ENTRY;
        rem_rd_reg <= rem_mem[e_reg[EW-1:0]];
        info_rd_reg <= info_mem[e_reg[EW-1:0]];
        if (next_we)
        begin
            next_mem[next_wa[EW-1:0]] <= next_wd;
        end
        if (rem_we)
        begin
            rem_mem[pl_e_reg[EW-1:0]] <= p_rem_reg;
        end
        if (info_we)
        begin
            info_mem[e_reg[EW-1:0]] <= {q_head.cmd.per, q_head.cmd.dly, q_head.cmd.id};
        end
    end

    // Valid bits of the links; an unwritten link reads as the free chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TIMERS; i++)
            begin
                next_vld_reg[i] <= 1'b0;
            end
            next_rv_reg <= 1'b0;
        end
        else
        begin
            next_rv_reg <= next_vld_reg[next_ra[EW-1:0]];
            if (next_we)
            begin
                next_vld_reg[next_wa[EW-1:0]] <= 1'b1;
            end
        end
    end

    // Result hand-off: a pending result goes out once the next one or the item end is known.
    assign push_pend = ((state_reg == S_EMIT) && (n_reg < MAX_RESULTS) && pend_v_reg &&
                        can_push) ||
                       ((state_reg == S_FIN) && pend_v_reg && can_push);
    assign push_last = (state_reg == S_FIN);
    assign q_pop = (state_reg == S_FIN) && (!pend_v_reg || can_push);

    always_ff @(posedge clk)
    begin
        if (push_pend)
        begin
            kind <= pend_kind_reg;
            fired_id <= pend_id_reg;
            status <= pend_st_reg;
            last <= push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (push_pend)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    // Filing datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_PDIV)
        begin
            plv_reg <= d_lvl;
            q0_reg <= d_prod[48:32];
        end
        if (state_reg == S_PFIX)
        begin
            p_slot_reg <= lvl_off(plv_reg) + SLOT_W'(f_slot_in);
            p_rem_reg <= f_r;
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_e_reg <= S_IDLE;
            ret_p_reg <= S_IDLE;
            lvl_reg <= LVL_SEC;
            for (int i = 0; i < 4; i++)
            begin
                base_reg[i] <= '0;
            end
            free_head_reg <= '0;
            e_reg <= '0;
            nx_reg <= NIL_ENTRY;
            f_per_reg <= 1'b0;
            f_dly_reg <= '0;
            n_reg <= '0;
            pend_v_reg <= 1'b0;
            pend_kind_reg <= KIND_STATUS;
            pend_id_reg <= '0;
            pend_st_reg <= ST_OK;
            em_kind_reg <= KIND_STATUS;
            em_id_reg <= '0;
            em_st_reg <= ST_OK;
            pl_e_reg <= '0;
            pl_d_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_head.valid)
                    begin
                        n_reg <= '0;
                        pend_v_reg <= 1'b0;
                        em_id_reg <= q_head.cmd.id;
                        em_kind_reg <= KIND_STATUS;
                        case (q_head.cmd.op)
                            CMD_TICK:
                            begin
                                lvl_reg <= LVL_SEC;
                                state_reg <= S_ADV;
                            end
                            CMD_INSERT:
                            begin
                                state_reg <= S_INS;
                            end
                            CMD_REJECT:
                            begin
                                em_st_reg <= ST_RANGE;
                                ret_e_reg <= S_FIN;
                                state_reg <= S_EMIT;
                            end
                            default:
                            begin
                                em_st_reg <= ST_OK;
                                ret_e_reg <= S_ZERO2;
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_ZERO2:
                begin
                    em_kind_reg <= KIND_FIRED;
                    em_st_reg <= ST_OK;
                    ret_e_reg <= S_FIN;
                    state_reg <= S_EMIT;
                end
                S_INS:
                begin
                    if (free_head_reg == NIL_ENTRY)
                    begin
                        em_st_reg <= ST_FULL;
                        ret_e_reg <= S_FIN;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        e_reg <= free_head_reg;
                        state_reg <= S_INS2;
                    end
                end
                S_INS2:
                begin
                    free_head_reg <= next_rd;
                    pl_e_reg <= e_reg;
                    pl_d_reg <= q_head.cmd.dly;
                    ret_p_reg <= S_INS3;
                    state_reg <= S_PDIV;
                end
                S_INS3:
                begin
                    em_st_reg <= ST_OK;
                    ret_e_reg <= S_FIN;
                    state_reg <= S_EMIT;
                end
                S_ADV:
                begin
                    if (adv_on)
                    begin
                        base_reg[lvl_reg] <= (7'(base_reg[lvl_reg]) + 7'd1 == lvl_size(lvl_reg)) ?
                                             6'd0 : base_reg[lvl_reg] + 6'd1;
                        state_reg <= S_ADV2;
                    end
                    else if (lvl_reg == LVL_DAY)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        lvl_reg <= lvl_reg + 2'd1;
                    end
                end
                S_ADV2:
                begin
                    e_reg <= head_rd;
                    state_reg <= S_WCHK;
                end
                S_WCHK:
                begin
                    if (e_reg != NIL_ENTRY)
                    begin
                        state_reg <= S_WDATA;
                    end
                    else if (lvl_reg == LVL_DAY)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        lvl_reg <= lvl_reg + 2'd1;
                        state_reg <= S_ADV;
                    end
                end
                S_WDATA:
                begin
                    nx_reg <= next_rd;
                    f_per_reg <= info_rd_reg[INFO_W-1];
                    f_dly_reg <= info_rd_reg[INFO_W-2:ID_W];
                    if (lvl_reg == LVL_SEC || rem_rd_reg == '0)
                    begin
                        em_kind_reg <= KIND_FIRED;
                        em_id_reg <= info_rd_reg[ID_W-1:0];
                        em_st_reg <= ST_OK;
                        ret_e_reg <= S_FPOST;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        pl_e_reg <= e_reg;
                        pl_d_reg <= rem_rd_reg;
                        ret_p_reg <= S_WNEXT;
                        state_reg <= S_PDIV;
                    end
                end
                S_FPOST:
                begin
                    if (f_per_reg && f_dly_reg != '0)
                    begin
                        pl_e_reg <= e_reg;
                        pl_d_reg <= f_dly_reg;
                        ret_p_reg <= S_WNEXT;
                        state_reg <= S_PDIV;
                    end
                    else
                    begin
                        free_head_reg <= e_reg;
                        state_reg <= S_WNEXT;
                    end
                end
                S_WNEXT:
                begin
                    e_reg <= nx_reg;
                    state_reg <= S_WCHK;
                end
                S_EMIT:
                begin
                    if (n_reg >= MAX_RESULTS)
                    begin
                        state_reg <= ret_e_reg;
                    end
                    else if (!pend_v_reg || can_push)
                    begin
                        pend_v_reg <= 1'b1;
                        pend_kind_reg <= em_kind_reg;
                        pend_id_reg <= em_id_reg;
                        pend_st_reg <= em_st_reg;
                        n_reg <= n_reg + 7'd1;
                        state_reg <= ret_e_reg;
                    end
                end
                S_FIN:
                begin
                    if (!pend_v_reg || can_push)
                    begin
                        pend_v_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                S_PDIV:
                begin
                    state_reg <= S_PFIX;
                end
                S_PFIX:
                begin
                    state_reg <= S_PRD;
                end
                S_PRD:
                begin
                    state_reg <= S_PAPP;
                end
                S_PAPP:
                begin
                    state_reg <= ret_p_reg;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The free list head always names a real entry or none.
    assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg == NIL_ENTRY) || (int'(free_head_reg) < MAX_TIMERS))
        else $error("free list head out of range");

    // No more results are reported per item than the cap allows.
    assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= MAX_RESULTS)
        else $error("result count above cap");

    // A result is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        push_pend |-> (!out_valid || out_ready))
        else $error("result register overwritten");

    // The queue head is only released when a command is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head.valid)
        else $error("pop of empty command queue");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the four-level timer wheel unit.
module tb_top
    import hwt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TIMERS = 64;
    localparam int LEVEL_OFF[4] = '{0, 60, 120, 144};
    localparam int LEVEL_SIZE[4] = '{60, 60, 24, 30};
    localparam int LEVEL_UNIT[4] = '{1, 60, 3600, 86400};

    typedef struct {
        logic               op;
        logic [TIME_W-1:0]  stamp;
        logic [ID_W-1:0]    id;
        logic [DELAY_W-1:0] dly;
        logic               per;
    } wheel_item_t;

    typedef struct {
        logic            kind;
        logic [ID_W-1:0] id;
        logic [1:0]      st;
        logic            last;
    } wheel_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               opcode = OP_TICK;
    logic [TIME_W-1:0]  now = '0;
    logic [ID_W-1:0]    timer_id = '0;
    logic [DELAY_W-1:0] delay = '0;
    logic               periodic = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               kind;
    logic [ID_W-1:0]    fired_id;
    logic [1:0]         status;
    logic               last;

    wheel_item_t   pending_items[$];
    wheel_result_t due_results[$];
    wheel_item_t   driven_item;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            mismatches = 0;
    logic [TIME_W-1:0] stim_now = TIME_W'(64'd1 << 40);

    // Shadow copy of the wheel state.
    bit [6:0]         slot_head[NUM_SLOTS];
    bit [6:0]         slot_tail[NUM_SLOTS];
    bit [ID_W-1:0]    ent_id[NUM_TIMERS];
    bit [DELAY_W-1:0] ent_dly[NUM_TIMERS];
    bit               ent_per[NUM_TIMERS];
    bit [6:0]         ent_next[NUM_TIMERS];
    bit [DELAY_W-1:0] ent_rem[NUM_TIMERS];
    bit [6:0]         free_ptr;
    bit               running;
    bit [TIME_W-1:0]  last_stamp;
    int               tick_cnt;
    int               wheel_base[4];
    int               fire_count;
    int               pushed_count;

    hierarchical_timer_wheel_unit #(.MAX_TIMERS(NUM_TIMERS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .now(now), .timer_id(timer_id), .delay(delay),
        .periodic(periodic),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .fired_id(fired_id), .status(status), .last(last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("tb_top NOT OK");
        $finish;
    end

    task automatic wheel_reset();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_head[i] = NIL_ENTRY;
            slot_tail[i] = NIL_ENTRY;
        end
        for (int i = 0; i < NUM_TIMERS; i++)
            ent_next[i] = (i + 1 < NUM_TIMERS) ? 7'(i + 1) : NIL_ENTRY;
        free_ptr = '0;
        running = 1'b0;
        last_stamp = '0;
        tick_cnt = 0;
        for (int l = 0; l < 4; l++)
            wheel_base[l] = 0;
    endtask

    // Record one result; firings past the per-item cap are dropped.
    task automatic push_result(logic k, logic [ID_W-1:0] id, logic [1:0] st);
        wheel_result_t r;
        if (fire_count < int'(MAX_RESULTS))
        begin
            r.kind = k;
            r.id = id;
            r.st = st;
            r.last = 1'b0;
            due_results = {due_results, r};
            pushed_count++;
        end
        fire_count++;
    endtask

    // File an entry at the coarsest level its delay reaches.
    task automatic file_entry(int e, int d);
        int lvl;
        int s;
        lvl = (d < 60) ? 0 : (d < 3600) ? 1 : (d < 86400) ? 2 : 3;
        s = LEVEL_OFF[lvl] + (wheel_base[lvl] + d / LEVEL_UNIT[lvl] - 1) % LEVEL_SIZE[lvl];
        ent_rem[e] = DELAY_W'(d % LEVEL_UNIT[lvl]);
        ent_next[e] = NIL_ENTRY;
        if (slot_head[s] == NIL_ENTRY)
            slot_head[s] = 7'(e);
        else
            ent_next[slot_tail[s]] = 7'(e);
        slot_tail[s] = 7'(e);
    endtask

    task automatic fire_entry(int e);
        push_result(KIND_FIRED, ent_id[e], ST_OK);
        if (ent_per[e] && ent_dly[e] != 0)
            file_entry(e, int'(ent_dly[e]));
        else
        begin
            ent_next[e] = free_ptr;
            free_ptr = 7'(e);
        end
    endtask

    // Detach the front slot of a level and handle its entries in list order.
    task automatic turn_wheel(int lvl);
        int s;
        int e;
        int nx;
        s = LEVEL_OFF[lvl] + wheel_base[lvl];
        e = slot_head[s];
        slot_head[s] = NIL_ENTRY;
        slot_tail[s] = NIL_ENTRY;
        wheel_base[lvl] = (wheel_base[lvl] + 1) % LEVEL_SIZE[lvl];
        while (e < NUM_TIMERS)
        begin
            nx = ent_next[e];
            if (lvl == 0 || ent_rem[e] == 0)
                fire_entry(e);
            else
                file_entry(e, int'(ent_rem[e]));
            e = nx;
        end
    endtask

    // Work out the results that one accepted item causes.
    task automatic predict_wheel(wheel_item_t it);
        int e;
        fire_count = 0;
        pushed_count = 0;
        if (it.op == OP_INSERT)
        begin
            if (it.dly / DAY_SECS > 30)
                push_result(KIND_STATUS, it.id, ST_RANGE);
            else if (it.dly == 0)
            begin
                push_result(KIND_STATUS, it.id, ST_OK);
                push_result(KIND_FIRED, it.id, ST_OK);
            end
            else if (free_ptr == NIL_ENTRY)
                push_result(KIND_STATUS, it.id, ST_FULL);
            else
            begin
                e = free_ptr;
                free_ptr = ent_next[e];
                ent_id[e] = it.id;
                ent_dly[e] = it.dly;
                ent_per[e] = it.per;
                file_entry(e, int'(it.dly));
                push_result(KIND_STATUS, it.id, ST_OK);
            end
        end
        else if (!running)
        begin
            running = 1'b1;
            last_stamp = it.stamp;
        end
        else if (it.stamp >= last_stamp)
        begin
            last_stamp = it.stamp;
            tick_cnt = (tick_cnt + 1) % 86400;
            turn_wheel(0);
            if (tick_cnt % 60 == 0)
                turn_wheel(1);
            if (tick_cnt % 3600 == 0)
                turn_wheel(2);
            if (tick_cnt == 0)
                turn_wheel(3);
        end
        if (pushed_count > 0)
            due_results[due_results.size() - 1].last = 1'b1;
    endtask

    // Driver: offer the next pending item, predicting each one as it is accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_wheel(driven_item);
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    driven_item = pending_items[0];
                    pending_items.delete(0);
                    opcode <= driven_item.op;
                    now <= driven_item.stamp;
                    timer_id <= driven_item.id;
                    delay <= driven_item.dly;
                    periodic <= driven_item.per;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall at random and compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        wheel_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result kind=%0d id=%0d status=%0d last=%0d",
                                 kind, fired_id, status, last);
                end
                else
                begin
                    want = due_results[0];
                    due_results.delete(0);
                    if (kind !== want.kind || fired_id !== want.id ||
                        status !== want.st || last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected kind=%0d id=%0d status=%0d last=%0d, %s",
                                     want.kind, want.id, want.st, want.last,
                                     $sformatf("got kind=%0d id=%0d status=%0d last=%0d",
                                               kind, fired_id, status, last));
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_tick(logic [TIME_W-1:0] stamp);
        wheel_item_t it;
        it.op = OP_TICK;
        it.stamp = stamp;
        it.id = ID_W'($urandom);
        it.dly = DELAY_W'($urandom);
        it.per = 1'($urandom);
        pending_items = {pending_items, it};
    endtask

    task automatic add_insert(int d, logic per);
        wheel_item_t it;
        it.op = OP_INSERT;
        it.stamp = TIME_W'({$urandom, $urandom});
        it.id = ID_W'($urandom);
        it.dly = DELAY_W'(d);
        it.per = per;
        pending_items = {pending_items, it};
    endtask

    // Mostly forward ticks with a few stale ones, and inserts over all levels.
    task automatic add_random(int count);
        int pick;
        int d;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                stim_now = stim_now + TIME_W'($urandom_range(1));
                add_tick(stim_now);
            end
            else if (pick < 60)
                add_tick(stim_now - TIME_W'($urandom_range(1, 1000)));
            else
            begin
                pick = $urandom_range(99);
                if (pick < 45)
                    d = $urandom_range(1, 59);
                else if (pick < 70)
                    d = $urandom_range(60, 3599);
                else if (pick < 80)
                    d = $urandom_range(3600, 86399);
                else if (pick < 85)
                    d = $urandom_range(86400, 2678399);
                else if (pick < 92)
                    d = $urandom_range(2678400, 4194303);
                else
                    d = 0;
                add_insert(d, (d >= 20 && $urandom_range(9) == 0) ? 1'b1 : 1'($urandom));
            end
        end
    endtask

    // Wait until every item is accepted and every expected result has come.
    task automatic drain();
        while (pending_items.size() > 0 || in_valid || due_results.size() > 0)
            @(negedge clk);
        repeat (1000) @(negedge clk);
    endtask

    initial
    begin
        logic [63:0] r;
        wheel_reset();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // First tick, then a full table, the capped burst of firings and full status.
        add_tick(stim_now);
        for (int i = 0; i < NUM_TIMERS + 1; i++)
            add_insert(2, 1'b0);
        stim_now = stim_now + 1;
        add_tick(stim_now);
        add_tick(stim_now);
        drain();

        // Directed edges: delay levels, limits, zero delay, stale and equal stamps.
        add_insert(0, 1'b1);
        add_insert(1, 1'b1);
        add_insert(59, 1'b0);
        add_insert(60, 1'b0);
        add_insert(61, 1'b1);
        add_insert(3599, 1'b0);
        add_insert(3600, 1'b0);
        add_insert(86399, 1'b0);
        add_insert(86400, 1'b0);
        add_insert(2678399, 1'b0);
        add_insert(2678400, 1'b0);
        add_insert(4194303, 1'b1);
        add_tick(stim_now);
        add_tick(stim_now - 1);
        stim_now = stim_now + 1;
        add_tick(stim_now);
        drain();

        // Random phases with each idling pattern.
        add_random(50);
        drain();
        send_idle_pct = 73;
        add_random(50);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 73;
        r = {$urandom, $urandom};
        stim_now = stim_now + {2'b00, r[60:0]};
        add_random(50);
        drain();
        send_idle_pct = 15;
        recv_stall_pct = 15;
        add_random(50);
        drain();

        // A run of ticks over at least two minute boundaries, then the largest and a zero stamp.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_insert(61, 1'b0);
        add_insert(119, 1'b0);
        add_insert(120, 1'b1);
        for (int i = 0; i < 130; i++)
        begin
            stim_now = stim_now + 1;
            add_tick(stim_now);
        end
        add_tick({TIME_W{1'b1}});
        add_tick('0);
        drain();

        if (mismatches == 0 && due_results.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// File: hierarchical_timer_wheel_unit.f
rtl/core/hwt_pkg.sv
rtl/core/hwt_front.sv
rtl/core/hwt_queue.sv
rtl/core/hwt_back.sv
rtl/core/hierarchical_timer_wheel_unit.sv
sim/tb_top.sv
